// ----- sv/tep_pkg.sv -----
// ----------------------------------------------------------------------------
// tep_pkg: shared definitions for the touch event to pointer core
// Event field widths, event codes, register map, configuration struct and
// reset values used by the register file and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tep_pkg;

  // Default coordinate width for stored raw and held positions
  localparam int COORD_BITS_DEF = 16;

  // Fixed field widths
  localparam int TYPE_W   = 5;
  localparam int CODE_W   = 10;
  localparam int VALUE_W  = 32;
  localparam int BATCH_W  = 6;
  localparam int AXIS_W   = 16;
  localparam int SCALE_W  = 24;
  localparam int PTR_W    = 16;
  localparam int FRAC_W   = 16;

  // Stream packing widths
  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = TYPE_W + CODE_W;
  localparam int OUT_DATA_W = 40;

  // Register port widths
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  // Event types and codes
  localparam logic [TYPE_W-1:0] TYPE_SYN    = 5'd0;
  localparam logic [TYPE_W-1:0] TYPE_ABS    = 5'd3;
  localparam logic [CODE_W-1:0] CODE_REPORT = 10'h000;
  localparam logic [CODE_W-1:0] CODE_POS_X  = 10'h035;
  localparam logic [CODE_W-1:0] CODE_POS_Y  = 10'h036;
  localparam logic [CODE_W-1:0] CODE_TRACK  = 10'h039;

  // Tracking ID value that marks a lifted finger
  localparam logic [VALUE_W-1:0] TRACK_LIFTED = 32'hFFFF_FFFF;

  // Without tracking IDs, a batch larger than this means a finger is down
  localparam logic [BATCH_W-1:0] BATCH_DOWN_MIN = 6'd2;

  typedef enum logic [1:0] {
    ORIENT_NONE    = 2'd0,
    ORIENT_QUARTER = 2'd1,
    ORIENT_HALF    = 2'd2,
    ORIENT_THREE_Q = 2'd3
  } orient_t;

  typedef enum logic [2:0] {
    REG_ORIENT   = 3'd0,
    REG_TRACK_EN = 3'd1,
    REG_X_MAX    = 3'd2,
    REG_Y_MAX    = 3'd3,
    REG_X_SCALE  = 3'd4,
    REG_Y_SCALE  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    orient_t              orientation;
    logic                 track_en;
    logic [AXIS_W-1:0]    x_max;
    logic [AXIS_W-1:0]    y_max;
    logic [SCALE_W-1:0]   x_scale;
    logic [SCALE_W-1:0]   y_scale;
  } cfg_t;

  typedef struct packed {
    logic [TYPE_W-1:0]  ev_type;
    logic [CODE_W-1:0]  ev_code;
    logic [VALUE_W-1:0] ev_value;
    logic [BATCH_W-1:0] batch;
  } ev_t;

  // Register reset values
  localparam orient_t            RST_ORIENT   = ORIENT_NONE;
  localparam logic               RST_TRACK_EN = 1'b1;
  localparam logic [AXIS_W-1:0]  RST_AXIS_MAX = 16'd4095;
  localparam logic [SCALE_W-1:0] RST_SCALE    = 24'd65536;

endpackage

`default_nettype wire

// ----- sv/tep_regs.sv -----
// ----------------------------------------------------------------------------
// tep_regs: configuration register file
// APB-style write and read access to orientation, tracking mode, axis maxima
// and scale factors. Always ready; writes land on the access cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tep_regs
  import tep_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
  assign cfg    = cfg_r;

  // Decode the write request into the addressed register
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_ORIENT:   cfg_nxt.orientation = orient_t'(pwdata[1:0]);
        REG_TRACK_EN: cfg_nxt.track_en    = pwdata[0];
        REG_X_MAX:    cfg_nxt.x_max       = pwdata[AXIS_W-1:0];
        REG_Y_MAX:    cfg_nxt.y_max       = pwdata[AXIS_W-1:0];
        REG_X_SCALE:  cfg_nxt.x_scale     = pwdata[SCALE_W-1:0];
        REG_Y_SCALE:  cfg_nxt.y_scale     = pwdata[SCALE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.orientation <= RST_ORIENT;
      cfg_r.track_en    <= RST_TRACK_EN;
      cfg_r.x_max       <= RST_AXIS_MAX;
      cfg_r.y_max       <= RST_AXIS_MAX;
      cfg_r.x_scale     <= RST_SCALE;
      cfg_r.y_scale     <= RST_SCALE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read back the addressed register
  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_ORIENT:   prdata = APB_DW'(cfg_r.orientation);
      REG_TRACK_EN: prdata = APB_DW'(cfg_r.track_en);
      REG_X_MAX:    prdata = APB_DW'(cfg_r.x_max);
      REG_Y_MAX:    prdata = APB_DW'(cfg_r.y_max);
      REG_X_SCALE:  prdata = APB_DW'(cfg_r.x_scale);
      REG_Y_SCALE:  prdata = APB_DW'(cfg_r.y_scale);
      default:      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/touch_event_to_pointer_core.sv -----
// ----------------------------------------------------------------------------
// touch_event_to_pointer_core: multitouch event stream to pointer reports
// Tracks raw X/Y and finger state from absolute-axis events; on each sync
// report emits the down flag and the held pointer, rotated and scaled.
//
//   channel  dir  bus     request carries
//   in_*     in   stream  one input event (type, code, value, batch size)
//   out_*    out  stream  one pointer report (down flag, X, Y)
//   cfg_*    in   APB     register writes and reads
//
// One event per cycle sustained while the output is not stalled. An event
// is captured in the input register, then the decode, rotate and coordinate
// by 24-bit scale multiply settle into the output register. Non-report
// events produce nothing. A stalled output holds its report; the input keeps
// accepting while the stage can drain into the output register.
// Synchronous reset clears the stages, the tracking state and the registers.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_event_to_pointer_core
  import tep_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // in_tdata: event_value [31:0], batch_size [37:32], zero pad [39:38]
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // in_tuser: event_type [4:0], event_code [14:5]
  input  wire logic [IN_USER_W-1:0]  in_tuser,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // out_tdata: touch_down [0], pointer_x [16:1], pointer_y [32:17], zero pad [39:33]
  output logic      [OUT_DATA_W-1:0] out_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [APB_AW-1:0]     cfg_paddr,
  input  wire logic [APB_DW-1:0]     cfg_pwdata,
  output logic      [APB_DW-1:0]     cfg_prdata,
  output logic                       cfg_pready
);

  localparam logic [COORD_BITS-1:0] CMAX = '1;
  localparam int SW = ((COORD_BITS > AXIS_W) ? COORD_BITS : AXIS_W) + 1;
  localparam int PW = (COORD_BITS > PTR_W) ? COORD_BITS : PTR_W;
  localparam int MW = COORD_BITS + SCALE_W;
  localparam int QW = MW - FRAC_W;

  // Clamp a signed event value to 0..CMAX
  function automatic logic [COORD_BITS-1:0] sat_value(input logic [VALUE_W-1:0] v);
    logic [COORD_BITS-1:0] r;
    if (v[VALUE_W-1]) begin
      r = '0;
    end else if (v > VALUE_W'(CMAX)) begin
      r = CMAX;
    end else begin
      r = v[COORD_BITS-1:0];
    end
    return r;
  endfunction

  // max - coord, floored at zero and clamped to CMAX
  function automatic logic [COORD_BITS-1:0] sat_sub(input logic [AXIS_W-1:0] a,
                                                    input logic [COORD_BITS-1:0] b);
    logic [SW-1:0] ae;
    logic [SW-1:0] be;
    logic [SW-1:0] d;
    logic [COORD_BITS-1:0] r;
    ae = SW'(a);
    be = SW'(b);
    d  = ae - be;
    if (ae < be) begin
      r = '0;
    end else if (d > SW'(CMAX)) begin
      r = CMAX;
    end else begin
      r = d[COORD_BITS-1:0];
    end
    return r;
  endfunction

  // coord * Q8.16 scale, drop the fraction, clamp to CMAX
  function automatic logic [COORD_BITS-1:0] scale_sat(input logic [COORD_BITS-1:0] c,
                                                      input logic [SCALE_W-1:0] s);
    logic [MW-1:0] p;
    logic [QW-1:0] q;
    logic [COORD_BITS-1:0] r;
    p = MW'(c) * MW'(s);
    q = p[MW-1:FRAC_W];
    if (q > QW'(CMAX)) begin
      r = CMAX;
    end else begin
      r = q[COORD_BITS-1:0];
    end
    return r;
  endfunction

  // Fit a held coordinate to the pointer field
  function automatic logic [PTR_W-1:0] to_ptr(input logic [COORD_BITS-1:0] h);
    logic [PW-1:0] e;
    e = PW'(h);
    return e[PTR_W-1:0];
  endfunction

  cfg_t cfg;

  tep_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Input stage
  logic s1_valid_r, s1_valid_nxt;
  ev_t  s1_ev_r;
  ev_t  in_ev;
  logic in_fire;
  logic s1_adv;

  // Tracking state
  logic [COORD_BITS-1:0] raw_x_r, raw_x_nxt;
  logic [COORD_BITS-1:0] raw_y_r, raw_y_nxt;
  logic                  finger_r, finger_nxt;
  logic [COORD_BITS-1:0] held_x_r, held_x_nxt;
  logic [COORD_BITS-1:0] held_y_r, held_y_nxt;

  // Output register
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_down_r;
  logic [COORD_BITS-1:0] out_x_r;
  logic [COORD_BITS-1:0] out_y_r;

  // Datapath terms
  logic                  is_abs;
  logic                  is_report;
  logic                  down;
  logic [COORD_BITS-1:0] rot_x;
  logic [COORD_BITS-1:0] rot_y;
  logic [COORD_BITS-1:0] sc_x;
  logic [COORD_BITS-1:0] sc_y;
  logic                  out_load;

  assign in_ev.ev_type  = in_tuser[TYPE_W-1:0];
  assign in_ev.ev_code  = in_tuser[IN_USER_W-1:TYPE_W];
  assign in_ev.ev_value = in_tdata[VALUE_W-1:0];
  assign in_ev.batch    = in_tdata[VALUE_W+BATCH_W-1:VALUE_W];

  // Decode the staged event
  assign is_abs    = (s1_ev_r.ev_type == TYPE_ABS);
  assign is_report = (s1_ev_r.ev_type == TYPE_SYN) && (s1_ev_r.ev_code == CODE_REPORT);
  assign down      = cfg.track_en ? finger_r : (s1_ev_r.batch > BATCH_DOWN_MIN);

  // Advance unless a report would overrun a full, stalled output
  assign s1_adv    = s1_valid_r && (!is_report || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;
  assign out_load  = s1_adv && is_report;

  // Rotate the raw position against the axis maxima
  always_comb begin
    case (cfg.orientation)
      ORIENT_QUARTER: begin
        rot_x = raw_y_r;
        rot_y = sat_sub(cfg.x_max, raw_x_r);
      end
      ORIENT_HALF: begin
        rot_x = sat_sub(cfg.x_max, raw_x_r);
        rot_y = sat_sub(cfg.y_max, raw_y_r);
      end
      ORIENT_THREE_Q: begin
        rot_x = sat_sub(cfg.y_max, raw_y_r);
        rot_y = raw_x_r;
      end
      default: begin
        rot_x = raw_x_r;
        rot_y = raw_y_r;
      end
    endcase
  end

  assign sc_x = scale_sat(rot_x, cfg.x_scale);
  assign sc_y = scale_sat(rot_y, cfg.y_scale);

  // Update tracking and held state as the event leaves the stage
  always_comb begin
    raw_x_nxt  = raw_x_r;
    raw_y_nxt  = raw_y_r;
    finger_nxt = finger_r;
    held_x_nxt = held_x_r;
    held_y_nxt = held_y_r;
    if (s1_adv) begin
      if (is_abs) begin
        if (cfg.track_en && (s1_ev_r.ev_code == CODE_TRACK)) begin
          finger_nxt = (s1_ev_r.ev_value != TRACK_LIFTED);
        end else if (s1_ev_r.ev_code == CODE_POS_X) begin
          raw_x_nxt = sat_value(s1_ev_r.ev_value);
        end else if (s1_ev_r.ev_code == CODE_POS_Y) begin
          raw_y_nxt = sat_value(s1_ev_r.ev_value);
        end
      end else if (is_report && down) begin
        held_x_nxt = sc_x;
        held_y_nxt = sc_y;
      end
    end
  end

  // Hold or drain the stage and output valids
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      raw_x_r     <= '0;
      raw_y_r     <= '0;
      finger_r    <= 1'b0;
      held_x_r    <= '0;
      held_y_r    <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      raw_x_r     <= raw_x_nxt;
      raw_y_r     <= raw_y_nxt;
      finger_r    <= finger_nxt;
      held_x_r    <= held_x_nxt;
      held_y_r    <= held_y_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_ev_r <= in_ev;
    end
    if (out_load) begin
      out_down_r <= down;
      out_x_r    <= held_x_nxt;
      out_y_r    <= held_y_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - 2*PTR_W - 1)'(0), to_ptr(out_y_r), to_ptr(out_x_r),
                       out_down_r};

endmodule

`default_nettype wire

// ----- sv/tep_checker.sv -----
// ----------------------------------------------------------------------------
// tep_checker: port-level checks for the touch event to pointer core
// Watches the stream and register ports for reset behavior, report latency
// and output hold under stall.
// ----------------------------------------------------------------------------
`default_nettype none

module tep_checker
  import tep_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic                  cfg_pready
);

  // Reset empties the output register and frees the input stage
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && in_tready))
    else $error("outputs not cleared after reset");

  // A fresh report must be preceded by an accepted request
  a_report_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("report appeared without a request two cycles earlier");

  // A stalled report holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled report changed or dropped");

  // Register port never waits
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("register port not ready");

endmodule

bind touch_event_to_pointer_core tep_checker u_tep_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .cfg_pready (cfg_pready)
);

`default_nettype wire
